// ===== rtl/rmq_pkg.sv =====
// Shared types and widths for the rotation-matrix-to-quaternion pipeline.
// No dependencies.
package rmq_pkg;

  localparam int IN_W   = 18;
  localparam int T_W    = 20;
  localparam int Q_W    = 21;
  localparam int MAG_W  = 20;
  localparam int SQ_W   = 40;
  localparam int SUM_W  = 42;
  localparam int RAD_W  = 58;
  localparam int ROOT_W = 29;
  localparam int REM_W  = 31;
  localparam int NUM_W  = 45;
  localparam int QUO_W  = 18;
  localparam int DREM_W = 30;
  localparam int DIV_DEPTH = QUO_W + 2;

  localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(65536);
  localparam logic [QUO_W-1:0] OUT_CLAMP = QUO_W'(131072);
  localparam logic [QUO_W-1:0] OUT_MAX   = QUO_W'(131071);

  typedef logic signed [IN_W-1:0] m_t;
  typedef logic signed [Q_W-1:0]  q_t;

  typedef struct packed {
    q_t   qx;
    q_t   qy;
    q_t   qz;
    q_t   qw;
    logic zero;
  } side_t;

  function automatic q_t ext_m(input m_t v);
    return {{(Q_W-IN_W){v[IN_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix (Q1.16) to unit quaternion xyzw (Q1.16), top level.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
// Input channel: nine signed Q1.16 matrix entries, transferred when in_valid
// is high and in_stall is low. Result channel: four signed Q1.16 quaternion
// components and norm_zero, transferred when out_valid is high and out_stall
// is low. norm_zero is set, with all components zero, when the unnormalized
// quaternion is zero.
// The path runs through 4 front stages, 29 square-root stages (one root bit
// each), 20 divider stages (one quotient bit each plus rounding setup and
// saturation) and the output register.
// Throughput is one matrix per cycle while the receiver does not stall.
// Reset clears all valid bits; the data registers are not reset.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; bubbles do not collapse.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  m_t   in_m00,
  input  m_t   in_m01,
  input  m_t   in_m02,
  input  m_t   in_m10,
  input  m_t   in_m11,
  input  m_t   in_m12,
  input  m_t   in_m20,
  input  m_t   in_m21,
  input  m_t   in_m22,
  output logic out_valid,
  input  logic out_stall,
  output m_t   out_quat_x,
  output m_t   out_quat_y,
  output m_t   out_quat_z,
  output m_t   out_quat_w,
  output logic out_norm_zero
);

  logic en;
  logic f_vld;
  logic [SUM_W-1:0] f_sum;
  side_t f_side;
  logic s_vld;
  logic [ROOT_W-1:0] s_root;
  side_t s_side;
  m_t dx, dy, dz, dw;

  logic [DIV_DEPTH-1:0] vld_pipe_r;
  logic [DIV_DEPTH-1:0] zero_pipe_r;
  logic out_valid_r;
  logic out_zero_r;
  m_t   out_x_r, out_y_r, out_z_r, out_w_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  rmq_front u_front (
    .clk, .rst_n, .en,
    .vld_in   (in_valid),
    .m00 (in_m00), .m01 (in_m01), .m02 (in_m02),
    .m10 (in_m10), .m11 (in_m11), .m12 (in_m12),
    .m20 (in_m20), .m21 (in_m21), .m22 (in_m22),
    .vld_out  (f_vld),
    .sum_out  (f_sum),
    .side_out (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .vld_in   (f_vld),
    .sum_in   (f_sum),
    .side_in  (f_side),
    .vld_out  (s_vld),
    .root_out (s_root),
    .side_out (s_side)
  );

  rmq_div u_div_x (.clk, .en, .q_in(s_side.qx), .n_in(s_root), .res_out(dx));
  rmq_div u_div_y (.clk, .en, .q_in(s_side.qy), .n_in(s_root), .res_out(dy));
  rmq_div u_div_z (.clk, .en, .q_in(s_side.qz), .n_in(s_root), .res_out(dz));
  rmq_div u_div_w (.clk, .en, .q_in(s_side.qw), .n_in(s_root), .res_out(dw));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_pipe_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_pipe_r  <= {vld_pipe_r[DIV_DEPTH-2:0], s_vld};
      out_valid_r <= vld_pipe_r[DIV_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_pipe_r <= {zero_pipe_r[DIV_DEPTH-2:0], s_side.zero};
      out_zero_r  <= zero_pipe_r[DIV_DEPTH-1];
      out_x_r     <= zero_pipe_r[DIV_DEPTH-1] ? '0 : dx;
      out_y_r     <= zero_pipe_r[DIV_DEPTH-1] ? '0 : dy;
      out_z_r     <= zero_pipe_r[DIV_DEPTH-1] ? '0 : dz;
      out_w_r     <= zero_pipe_r[DIV_DEPTH-1] ? '0 : dw;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_quat_x    = out_x_r;
  assign out_quat_y    = out_y_r;
  assign out_quat_z    = out_z_r;
  assign out_quat_w    = out_w_r;
  assign out_norm_zero = out_zero_r;

endmodule

// ===== rtl/rmq_front.sv =====
// Front stages: trace, Shepperd selection, component squares, sum of squares.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  m_t               m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic             vld_out,
  output logic [SUM_W-1:0] sum_out,
  output side_t            side_out
);

  typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z, SEL_W} sel_t;

  logic [2:0] vld_r;
  m_t a00_r, a01_r, a02_r, a10_r, a11_r, a12_r, a20_r, a21_r, a22_r;
  q_t t_r;
  q_t qx_r, qy_r, qz_r, qw_r;
  q_t qx2_r, qy2_r, qz2_r, qw2_r;
  logic [SQ_W-1:0] sx_r, sy_r, sz_r, sw_r;
  logic [SUM_W-1:0] sum_r;
  side_t side_r;

  q_t t_nxt;
  sel_t sel;
  q_t best;
  q_t qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic [MAG_W-1:0] mx, my, mz, mw;
  logic [SUM_W-1:0] sum_nxt;

  function automatic logic [MAG_W-1:0] mag(input q_t v);
    q_t a;
    a = v[Q_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  assign t_nxt = ext_m(m00) + ext_m(m11) + ext_m(m22);

  always_comb begin
    sel  = SEL_X;
    best = ext_m(a00_r);
    if (ext_m(a11_r) > best) begin
      sel  = SEL_Y;
      best = ext_m(a11_r);
    end
    if (ext_m(a22_r) > best) begin
      sel  = SEL_Z;
      best = ext_m(a22_r);
    end
    if (t_r > best) begin
      sel = SEL_W;
    end
    case (sel)
      SEL_X: begin
        qx_nxt = ONE_Q - t_r + (ext_m(a00_r) <<< 1);
        qy_nxt = ext_m(a10_r) + ext_m(a01_r);
        qz_nxt = ext_m(a20_r) + ext_m(a02_r);
        qw_nxt = ext_m(a21_r) - ext_m(a12_r);
      end
      SEL_Y: begin
        qy_nxt = ONE_Q - t_r + (ext_m(a11_r) <<< 1);
        qz_nxt = ext_m(a21_r) + ext_m(a12_r);
        qx_nxt = ext_m(a01_r) + ext_m(a10_r);
        qw_nxt = ext_m(a02_r) - ext_m(a20_r);
      end
      SEL_Z: begin
        qz_nxt = ONE_Q - t_r + (ext_m(a22_r) <<< 1);
        qx_nxt = ext_m(a02_r) + ext_m(a20_r);
        qy_nxt = ext_m(a12_r) + ext_m(a21_r);
        qw_nxt = ext_m(a10_r) - ext_m(a01_r);
      end
      default: begin
        qx_nxt = ext_m(a21_r) - ext_m(a12_r);
        qy_nxt = ext_m(a02_r) - ext_m(a20_r);
        qz_nxt = ext_m(a10_r) - ext_m(a01_r);
        qw_nxt = ONE_Q + t_r;
      end
    endcase
  end

  assign mx = mag(qx_r);
  assign my = mag(qy_r);
  assign mz = mag(qz_r);
  assign mw = mag(qw_r);

  assign sum_nxt = SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r) + SUM_W'(sw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[1:0], vld_in};
      vld_out <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a00_r <= m00; a01_r <= m01; a02_r <= m02;
      a10_r <= m10; a11_r <= m11; a12_r <= m12;
      a20_r <= m20; a21_r <= m21; a22_r <= m22;
      t_r   <= t_nxt;
      qx_r  <= qx_nxt; qy_r <= qy_nxt; qz_r <= qz_nxt; qw_r <= qw_nxt;
      sx_r  <= SQ_W'(mx) * SQ_W'(mx);
      sy_r  <= SQ_W'(my) * SQ_W'(my);
      sz_r  <= SQ_W'(mz) * SQ_W'(mz);
      sw_r  <= SQ_W'(mw) * SQ_W'(mw);
      qx2_r <= qx_r; qy2_r <= qy_r; qz2_r <= qz_r; qw2_r <= qw_r;
      sum_r <= sum_nxt;
      side_r.qx   <= qx2_r;
      side_r.qy   <= qy2_r;
      side_r.qz   <= qz2_r;
      side_r.qw   <= qw2_r;
      side_r.zero <= (sum_nxt == '0);
    end
  end

  assign sum_out  = sum_r;
  assign side_out = side_r;

endmodule

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  logic [SUM_W-1:0]  sum_in,
  input  side_t             side_in,
  output logic              vld_out,
  output logic [ROOT_W-1:0] root_out,
  output side_t             side_out
);

  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    side_t             side_p;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_p  = vld_in;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = {sum_in, (RAD_W-SUM_W)'(0)};
      assign side_p = side_in;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign rem_sh = {rem_p[REM_W-3:0], rad_p[RAD_W-1:RAD_W-2]};
    assign trial  = {root_p, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_p[ROOT_W-2:0], take};
        rad_r[k]  <= rad_p << 2;
        side_r[k] <= side_p;
      end
    end
  end

  assign vld_out  = vld_r[ROOT_W-1];
  assign root_out = root_r[ROOT_W-1];
  assign side_out = side_r[ROOT_W-1];

endmodule

// ===== rtl/rmq_div.sv =====
// Pipelined restoring divider: rounds q * 2^24 / n and saturates to Q1.16.
// Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  q_t                q_in,
  input  logic [ROOT_W-1:0] n_in,
  output m_t                res_out
);

  logic              neg0_r;
  logic [DREM_W-1:0] rem0_r;
  logic [QUO_W-1:0]  lo0_r;
  logic [ROOT_W-1:0] n0_r;

  logic              neg_r [QUO_W];
  logic [DREM_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0]  lo_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];
  logic [ROOT_W-1:0] n_r   [QUO_W];

  m_t res_r;

  q_t               qabs;
  logic [NUM_W-1:0] num;
  logic [QUO_W-1:0] rq;
  logic signed [QUO_W:0] sres;

  assign qabs = q_in[Q_W-1] ? -q_in : q_in;
  assign num  = {1'b0, qabs[MAG_W-1:0], 24'b0} + NUM_W'(n_in >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= q_in[Q_W-1];
      rem0_r <= DREM_W'(num[NUM_W-1:QUO_W]);
      lo0_r  <= num[QUO_W-1:0];
      n0_r   <= n_in;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic              neg_p;
    logic [DREM_W-1:0] rem_p;
    logic [QUO_W-1:0]  lo_p;
    logic [QUO_W-1:0]  quo_p;
    logic [ROOT_W-1:0] n_p;
    logic [DREM_W-1:0] rem_sh;
    logic              take;

    if (k == 0) begin : g_first
      assign neg_p = neg0_r;
      assign rem_p = rem0_r;
      assign lo_p  = lo0_r;
      assign quo_p = '0;
      assign n_p   = n0_r;
    end else begin : g_next
      assign neg_p = neg_r[k-1];
      assign rem_p = rem_r[k-1];
      assign lo_p  = lo_r[k-1];
      assign quo_p = quo_r[k-1];
      assign n_p   = n_r[k-1];
    end

    assign rem_sh = {rem_p[DREM_W-2:0], lo_p[QUO_W-1]};
    assign take   = (rem_sh >= DREM_W'(n_p));

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k] <= neg_p;
        rem_r[k] <= take ? rem_sh - DREM_W'(n_p) : rem_sh;
        lo_r[k]  <= lo_p << 1;
        quo_r[k] <= {quo_p[QUO_W-2:0], take};
        n_r[k]   <= n_p;
      end
    end
  end

  always_comb begin
    rq = (quo_r[QUO_W-1] > OUT_CLAMP) ? OUT_CLAMP : quo_r[QUO_W-1];
    if (neg_r[QUO_W-1]) begin
      sres = -$signed({1'b0, rq});
    end else if (rq > OUT_MAX) begin
      sres = $signed({1'b0, OUT_MAX});
    end else begin
      sres = $signed({1'b0, rq});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= sres[IN_W-1:0];
    end
  end

  assign res_out = res_r;

endmodule
